### rtl/core/sacl_pkg.sv
// shared types and constants of the set-associative cache lru directory
package sacl_pkg;

  localparam int unsigned MAX_WAYS_DEF = 8;
  localparam int unsigned MAX_SETS_DEF = 256;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned AGE_W  = 16;
  localparam int unsigned WAY_OUT_W = 3;

  localparam logic [AGE_W-1:0] AGE_MAX = 16'hFFFF;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

  localparam logic [2:0] OFFSET_BITS_RST = 3'd4;
  localparam logic [3:0] INDEX_BITS_RST  = 4'd6;
  localparam logic [3:0] WAYS_IN_USE_RST = 4'd2;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             tag_eq;
    logic             age_gt;
    logic [AGE_W-1:0] age_next;
  } way_res_t;

endpackage

### rtl/core/sacl_ram.sv
// generic single write port ram with registered read
module sacl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/sacl_way_unit.sv
// shared per-way unit: tag compare, age compare and saturating age step
module sacl_way_unit (
  input  sacl_pkg::entry_t                entry_i,
  input  logic [sacl_pkg::TAG_W-1:0]      tag_i,
  input  logic [sacl_pkg::AGE_W-1:0]      best_age_i,
  output sacl_pkg::way_res_t              res_o
);

  logic tag_eq;

  assign tag_eq = (entry_i.tag == tag_i);

  always_comb begin
    res_o.tag_eq   = tag_eq;
    res_o.age_gt   = (entry_i.age > best_age_i);
    res_o.age_next = entry_i.age;
    if (!tag_eq && (entry_i.age != sacl_pkg::AGE_MAX)) begin
      res_o.age_next = entry_i.age + 16'd1;
    end
  end

endmodule

### rtl/core/set_assoc_cache_lru_directory_top.sv
// top level of the set-associative cache tag directory with age lru
//
//   channel  | signals                               | direction
//   ---------+---------------------------------------+----------
//   in       | in_valid_i in_ready_o load_address_i  | item in
//   out      | out_valid_o out_ready_i hit_o         | item out
//            | way_used_o                            |
//   cfg      | cfg_we_i cfg_index_i cfg_data_i       | write only
//
// one item at a time: a new item is taken only after the last write-back;
// n = ways searched (1..MAX_WAYS). address split, set reduce, row read and load
// run first, the shared way unit then scans the n ways, then the row write-back.
// reset marks every set row empty through one flag per set, no clearing pass.
// a pending result stalls only the write-back of the next item.
module set_assoc_cache_lru_directory_top #(
  parameter int unsigned MAX_WAYS = sacl_pkg::MAX_WAYS_DEF,
  parameter int unsigned MAX_SETS = sacl_pkg::MAX_SETS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [sacl_pkg::ADDR_W-1:0]       load_address_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              hit_o,
  output logic [sacl_pkg::WAY_OUT_W-1:0]    way_used_o,
  input  logic                              cfg_we_i,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_WAYS + 1);
  localparam int unsigned SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned ROW_W = MAX_WAYS * sacl_pkg::ENTRY_W;
  localparam logic [32:0] SET_RECIP = 33'(64'h1_0000_0000 / 64'(MAX_SETS));

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SPLIT = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_MOD   = 8'b0000_1000,
    S_READ  = 8'b0001_0000,
    S_LOAD  = 8'b0010_0000,
    S_SCAN  = 8'b0100_0000,
    S_WRITE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [2:0] offset_bits_q;
  logic [3:0] index_bits_q;
  logic [3:0] ways_in_use_q;

  logic [sacl_pkg::ADDR_W-1:0] addr_q;
  logic [CNT_W-1:0]            nw_q;
  logic [CNT_W-1:0]            nw_d;
  logic [15:0]                 set_raw_q;
  logic [sacl_pkg::TAG_W-1:0]  tag_q;
  logic [48:0]                 prod_q;
  logic [SET_W-1:0]            set_q;
  logic [MAX_SETS-1:0]         row_init_q;

  sacl_pkg::entry_t [MAX_WAYS-1:0] row_q;
  sacl_pkg::entry_t [MAX_WAYS-1:0] wrow;
  logic [ROW_W-1:0]                ram_rdata;

  logic [WAY_W-1:0]            way_q;
  logic                        hit_q;
  logic [WAY_W-1:0]            hit_way_q;
  logic                        inv_q;
  logic [WAY_W-1:0]            inv_way_q;
  logic [WAY_W-1:0]            best_way_q;
  logic [sacl_pkg::AGE_W-1:0]  best_age_q;
  logic [WAY_W-1:0]            used_way;

  logic                        out_valid_q;
  logic                        hit_out_q;
  logic [sacl_pkg::WAY_OUT_W-1:0] way_out_q;

  logic [4:0]                  shift_sum;
  logic [15:0]                 idx_mask;
  logic [31:0]                 rem;
  logic [31:0]                 rem_fix;
  logic                        in_fire;
  logic                        scan_last;
  logic                        write_fire;

  sacl_pkg::entry_t            cur_entry;
  sacl_pkg::way_res_t          way_res;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_out_q;
  assign way_used_o  = way_out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= sacl_pkg::OFFSET_BITS_RST;
      index_bits_q  <= sacl_pkg::INDEX_BITS_RST;
      ways_in_use_q <= sacl_pkg::WAYS_IN_USE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sacl_pkg::CFG_OFFSET_BITS: offset_bits_q <= cfg_data_i[2:0];
        sacl_pkg::CFG_INDEX_BITS:  index_bits_q  <= cfg_data_i;
        sacl_pkg::CFG_WAYS_IN_USE: ways_in_use_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ways_in_use_q == 4'd0) begin
      nw_d = CNT_W'(1);
    end else if (5'(ways_in_use_q) > 5'(MAX_WAYS)) begin
      nw_d = CNT_W'(MAX_WAYS);
    end else begin
      nw_d = CNT_W'(ways_in_use_q);
    end
  end

  // address split and set reduction
  assign shift_sum = 5'(offset_bits_q) + 5'(index_bits_q);
  assign idx_mask  = 16'((17'd1 << index_bits_q) - 17'd1);
  assign rem       = 32'(set_raw_q) - 32'(prod_q[48:32]) * 32'(MAX_SETS);
  assign rem_fix   = (rem >= 32'(MAX_SETS)) ? rem - 32'(MAX_SETS) : rem;

  // shared way unit
  assign cur_entry = row_q[way_q];

  sacl_way_unit u_way_unit (
    .entry_i    (cur_entry),
    .tag_i      (tag_q),
    .best_age_i (best_age_q),
    .res_o      (way_res)
  );

  assign scan_last  = (CNT_W'(way_q) == nw_q - CNT_W'(1));
  assign write_fire = (state_q == S_WRITE) && (!out_valid_q || out_ready_i);

  always_comb begin
    if (hit_q) begin
      used_way = hit_way_q;
    end else if (inv_q) begin
      used_way = inv_way_q;
    end else begin
      used_way = best_way_q;
    end
  end

  always_comb begin
    wrow = row_q;
    wrow[used_way].valid = 1'b1;
    wrow[used_way].tag   = tag_q;
    wrow[used_way].age   = '0;
  end

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (write_fire),
    .waddr_i (set_q),
    .wdata_i (wrow),
    .raddr_i (set_q),
    .rdata_o (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire) state_d = S_SPLIT;
      S_SPLIT: state_d = S_MUL;
      S_MUL:   state_d = S_MOD;
      S_MOD:   state_d = S_READ;
      S_READ:  state_d = S_LOAD;
      S_LOAD:  state_d = S_SCAN;
      S_SCAN:  if (scan_last) state_d = S_WRITE;
      S_WRITE: if (write_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      row_init_q  <= '0;
      way_q       <= '0;
      hit_q       <= 1'b0;
      inv_q       <= 1'b0;
      nw_q        <= CNT_W'(1);
    end else begin
      state_q <= state_d;
      if (write_fire) begin
        out_valid_q        <= 1'b1;
        row_init_q[set_q]  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire) begin
        nw_q <= nw_d;
      end
      if (state_q == S_LOAD) begin
        way_q <= '0;
        hit_q <= 1'b0;
        inv_q <= 1'b0;
      end else if (state_q == S_SCAN) begin
        if (!scan_last) begin
          way_q <= way_q + WAY_W'(1);
        end
        if (!hit_q && cur_entry.valid && way_res.tag_eq) begin
          hit_q <= 1'b1;
        end
        if (!inv_q && !cur_entry.valid) begin
          inv_q <= 1'b1;
        end
      end
    end
  end

  // item payload and row buffer
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      addr_q <= load_address_i;
    end
    if (state_q == S_SPLIT) begin
      set_raw_q <= (addr_q >> offset_bits_q) & idx_mask;
      tag_q     <= (shift_sum >= 5'd16) ? '0 : (addr_q >> shift_sum);
    end
    if (state_q == S_MUL) begin
      prod_q <= 49'(set_raw_q) * 49'(SET_RECIP);
    end
    if (state_q == S_MOD) begin
      set_q <= SET_W'(rem_fix);
    end
    if (state_q == S_LOAD) begin
      row_q <= row_init_q[set_q] ? ram_rdata : '0;
    end
    if (state_q == S_SCAN) begin
      row_q[way_q].age <= way_res.age_next;
      if (!hit_q && cur_entry.valid && way_res.tag_eq) begin
        hit_way_q <= way_q;
      end
      if (!inv_q && !cur_entry.valid) begin
        inv_way_q <= way_q;
      end
      if ((way_q == '0) || way_res.age_gt) begin
        best_way_q <= way_q;
        best_age_q <= cur_entry.age;
      end
    end
    if (write_fire) begin
      hit_out_q <= hit_q;
      way_out_q <= sacl_pkg::WAY_OUT_W'(used_way);
    end
  end

`ifndef SYNTHESIS
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CNT_W'(way_q) < nw_q))
    else $error("way scan beyond ways in use");

  a_used_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> (CNT_W'(used_way) < nw_q))
    else $error("filled way beyond ways in use");

  a_ways_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nw_q != '0) && (nw_q <= CNT_W'(MAX_WAYS)))
    else $error("active way count out of bounds");

  a_result_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_fire |=> (out_valid_o && (state_q == S_IDLE)))
    else $error("write-back did not present a result");
`endif

endmodule

### tb/sv/lru_directory_checker.sv
`timescale 1ns / 100ps
// lookup checker: mirrors the lru tag directory and compares every result item
module lru_directory_checker
  import sacl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [ADDR_W-1:0]     load_address_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic                  hit_i,
  input  logic [WAY_OUT_W-1:0]  way_used_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    pending_o,
  output int                    errors_o,
  output int                    lookups_o,
  output int                    hits_o
);

  localparam int unsigned WAYS  = MAX_WAYS_DEF;
  localparam int unsigned SETS  = MAX_SETS_DEF;
  localparam int unsigned LINES = SETS * WAYS;

  typedef struct packed {
    logic [ADDR_W-1:0]    addr;
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
  } lookup_t;

  logic             line_valid_q [LINES];
  logic [TAG_W-1:0] line_tag_q   [LINES];
  logic [AGE_W-1:0] line_age_q   [LINES];

  logic [2:0] offset_bits_q;
  logic [3:0] index_bits_q;
  logic [3:0] ways_in_use_q;

  lookup_t expected_lookups [$];
  lookup_t predicted;
  lookup_t oldest;
  int      err_cnt;
  int      lookup_cnt;
  int      hit_cnt;

  assign errors_o  = err_cnt;
  assign lookups_o = lookup_cnt;
  assign hits_o    = hit_cnt;

  // search, fill or evict, then age the set
  function automatic lookup_t lookup_way(input logic [ADDR_W-1:0] addr);
    int unsigned a, nw, set_idx, shift, base, used, best, w;
    logic [TAG_W-1:0] tag;
    logic hit, found;
    lookup_t res;
    a = addr;
    if (ways_in_use_q == 0) nw = 1;
    else if (ways_in_use_q > WAYS) nw = WAYS;
    else nw = ways_in_use_q;
    set_idx = (a >> offset_bits_q) & ((32'd1 << index_bits_q) - 32'd1);
    set_idx = set_idx % SETS;
    shift = offset_bits_q + index_bits_q;
    tag = (shift >= 16) ? '0 : TAG_W'(a >> shift);
    base = set_idx * WAYS;
    hit = 1'b0;
    found = 1'b0;
    used = 0;
    best = 0;
    for (w = 0; w < nw; w++) begin
      if (line_valid_q[base+w] && line_tag_q[base+w] == tag) begin
        hit = 1'b1;
        used = w;
        break;
      end
    end
    if (!hit) begin
      for (w = 0; w < nw; w++) begin
        if (!line_valid_q[base+w]) begin
          used = w;
          found = 1'b1;
          break;
        end
        if (line_age_q[base+w] > line_age_q[base+best]) best = w;
      end
      if (!found) used = best;
      line_tag_q[base+used] = tag;
      line_valid_q[base+used] = 1'b1;
    end
    line_age_q[base+used] = '0;
    for (w = 0; w < nw; w++) begin
      if (line_tag_q[base+w] != tag && line_age_q[base+w] != AGE_MAX)
        line_age_q[base+w] = line_age_q[base+w] + 1'b1;
    end
    res.addr = addr;
    res.hit = hit;
    res.way = WAY_OUT_W'(used);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LINES; i++) begin
        line_valid_q[i] = 1'b0;
        line_tag_q[i] = '0;
        line_age_q[i] = '0;
      end
      offset_bits_q = OFFSET_BITS_RST;
      index_bits_q = INDEX_BITS_RST;
      ways_in_use_q = WAYS_IN_USE_RST;
      expected_lookups.delete();
      err_cnt = 0;
      lookup_cnt = 0;
      hit_cnt = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_OFFSET_BITS: offset_bits_q = cfg_data_i[2:0];
          CFG_INDEX_BITS:  index_bits_q = cfg_data_i;
          CFG_WAYS_IN_USE: ways_in_use_q = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_lookups.size() == 0) begin
          $error("result item with no lookup waiting: hit %0d way_used %0d",
                 hit_i, way_used_i);
          err_cnt++;
        end else begin
          oldest = expected_lookups.pop_front();
          if (hit_i !== oldest.hit) begin
            $error("hit mismatch, address %h: expected %0d, actual %0d",
                   oldest.addr, oldest.hit, hit_i);
            err_cnt++;
          end
          if (way_used_i !== oldest.way) begin
            $error("way_used mismatch, address %h: expected %0d, actual %0d",
                   oldest.addr, oldest.way, way_used_i);
            err_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predicted = lookup_way(load_address_i);
        expected_lookups.push_back(predicted);
        lookup_cnt++;
        if (predicted.hit) hit_cnt++;
      end
      pending_o <= expected_lookups.size();
    end
  end

endmodule

### tb/sv/set_assoc_cache_lru_directory_top_tb.sv
`timescale 1ns / 100ps
// testbench top: clock, reset, register writes, load stimulus and verdict
module set_assoc_cache_lru_directory_top_tb;
  import sacl_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS   = 105;
  localparam int unsigned SOAK_HITS     = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [6:0][15:0] RESET_CFG_LOADS =
    {16'h0000, 16'hFFFF, 16'h0000, 16'h0400, 16'h0800, 16'h0400, 16'h0000};
  localparam logic [3:0][15:0] WIDE_CFG_LOADS =
    {16'h0000, 16'h8000, 16'h7F80, 16'hFFFF};
  localparam logic [3:0][15:0] NARROW_CFG_LOADS =
    {16'h1234, 16'h1234, 16'hFFFF, 16'h0001};

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ADDR_W-1:0]     load_address = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  hit;
  logic [WAY_OUT_W-1:0]  way_used;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic        quiet = 1'b0;
  logic        hold_req = 1'b0;
  logic        steady = 1'b0;
  int unsigned cycles = 0;
  int          configs = 0;
  int          pending, errors, lookups, hits;
  int unsigned cur_offset, cur_index;
  logic [ADDR_W-1:0] addr_pool [16];

  always #2 clk_i = ~clk_i;

  set_assoc_cache_lru_directory_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .load_address_i (load_address),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .hit_o          (hit),
    .way_used_o     (way_used),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  lru_directory_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .load_address_i (load_address),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .hit_i          (hit),
    .way_used_i     (way_used),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .pending_o      (pending),
    .errors_o       (errors),
    .lookups_o      (lookups),
    .hits_o         (hits)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d lookups pending", cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    logic        held;
    logic        rdy;
    int unsigned len;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        rdy = 1'b0;
        len = HOLD_CYCLES;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        rdy = 1'b0;
        len = $urandom_range(1, 15);
      end else begin
        rdy = 1'b1;
        len = quiet ? 1 : $urandom_range(1, 20);
      end
      out_ready <= rdy;
      repeat (len) @(posedge clk_i);
    end
  end

  task automatic offer(input logic [ADDR_W-1:0] addr);
    in_valid <= 1'b1;
    load_address <= addr;
    do @(posedge clk_i); while (!in_ready);
    if (!quiet && !steady && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [3:0] offset, input logic [3:0] index,
                              input logic [3:0] ways, input logic poke_unused);
    cfg_we <= 1'b1;
    cfg_index <= CFG_OFFSET_BITS;
    cfg_data <= offset;
    @(posedge clk_i);
    cfg_index <= CFG_INDEX_BITS;
    cfg_data <= index;
    @(posedge clk_i);
    cfg_index <= CFG_WAYS_IN_USE;
    cfg_data <= ways;
    @(posedge clk_i);
    if (poke_unused) begin
      cfg_index <= CFG_UNUSED;
      cfg_data <= 4'($urandom_range(0, 15));
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    cur_offset = offset[2:0];
    cur_index = index;
    configs++;
  endtask

  initial begin
    int unsigned set_a, set_b, tag_v, set_v;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: invalid ways, aging of invalid lines, eviction
    for (int i = 6; i >= 0; i--) offer(RESET_CFG_LOADS[i]);
    drain_all();
    // widest fields: tag forced to zero, set index wraps, ways saturate
    write_config(4'd7, 4'd15, 4'd15, 1'b0);
    for (int i = 3; i >= 0; i--) offer(WIDE_CFG_LOADS[i]);
    drain_all();
    // one set, whole address as tag, zero ways acts as one
    write_config(4'd0, 4'd0, 4'd0, 1'b0);
    for (int i = 3; i >= 0; i--) offer(NARROW_CFG_LOADS[i]);
    drain_all();
    // all eight ways filled then an eviction
    write_config(4'd3, 4'd2, 4'd8, 1'b0);
    for (int i = 1; i <= 9; i++) offer(16'(i << 5));
    drain_all();

    // repeated hits on one way, then the oldest way is evicted
    write_config(4'd0, 4'd0, 4'd3, 1'b0);
    quiet <= 1'b1;
    offer(16'h1111);
    offer(16'h2222);
    offer(16'h3333);
    offer(16'h2222);
    for (int i = 0; i < SOAK_HITS; i++) offer(16'h1111);
    offer(16'h4444);
    drain_all();
    quiet <= 1'b0;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_all();
      if (p == RANDOM_PHASES - 1) quiet <= 1'b1;
      write_config(4'($urandom_range(0, 15)),
                   4'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, 3)),
                   4'($urandom_range(0, 15)), $urandom_range(0, 2) == 0);
      // working set of a few tags over two sets to force hits and evictions
      set_a = $urandom_range(0, 65535);
      set_b = $urandom_range(0, 65535);
      for (int k = 0; k < 16; k++) begin
        tag_v = $urandom_range(0, 11);
        set_v = k[0] ? set_a : set_b;
        addr_pool[k] = 16'((tag_v << (cur_offset + cur_index))
                           | ((set_v & ((32'd1 << cur_index) - 1)) << cur_offset)
                           | ($urandom_range(0, 65535) & ((32'd1 << cur_offset) - 1)));
      end
      steady = (p == 2);
      if (p == 2) hold_req <= 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 3) == 0) offer(16'($urandom_range(0, 65535)));
        else offer(addr_pool[$urandom_range(0, 15)]);
      end
      steady = 1'b0;
    end
    drain_all();

    $display("%0d lookups checked, %0d hits, over %0d register settings", lookups, hits,
             configs);
    $display("included field extremes, wrapped sets, evictions and a long stall");
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### set_assoc_cache_lru_directory_top.f
rtl/core/sacl_pkg.sv
rtl/core/sacl_ram.sv
rtl/core/sacl_way_unit.sv
rtl/core/set_assoc_cache_lru_directory_top.sv
tb/sv/lru_directory_checker.sv
tb/sv/set_assoc_cache_lru_directory_top_tb.sv
